### design/cnf_eval_pkg.sv
// Shared types and constants for the CNF clause evaluator.
// No dependencies; imported by cnf_clause_evaluator_core.
package cnf_eval_pkg;

   // Width of the variable number carried by a request.
   localparam int VAR_INDEX_W = 16;

   // Assignment table entry codes.
   localparam int ENTRY_W = 2;
   localparam logic [ENTRY_W-1:0] ENTRY_UNASSIGNED = 2'd0;
   localparam logic [ENTRY_W-1:0] ENTRY_FALSE      = 2'd2;
   localparam logic [ENTRY_W-1:0] ENTRY_TRUE       = 2'd3;

   // Request operations.
   typedef enum logic [1:0] {
      OP_ASSIGN   = 2'd0,
      OP_UNASSIGN = 2'd1,
      OP_LITERAL  = 2'd2,
      OP_CLOSE    = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type             opcode;
      logic [VAR_INDEX_W-1:0] variable_index;
      logic                   assign_value;
      logic                   literal_negated;
      logic                   last_in_clause;
      logic                   last_in_formula;
   } req_payload_type;

   typedef struct packed {
      logic clause_valid;
      logic clause_complete;
      logic formula_valid;
      logic formula_complete;
      logic formula_end;
      logic bad_literal;
   } rsp_payload_type;

endpackage

### design/cnf_clause_evaluator_core.sv
// Top level of the CNF clause evaluator: assignment table, clause and formula flags.
// Depends on cnf_eval_pkg for payload types, opcodes and table entry codes.
//
//   Channel  Direction  Handshake              Payload
//   req_     in         req_valid / req_ready  req_data  (req_payload_type)
//   rsp_     out        rsp_valid / rsp_ready  rsp_data  (rsp_payload_type)
//
// One request is accepted per cycle while req_ready is high. A request is registered
// together with its table read; from that input stage it is evaluated against the clause
// flags and, for a closing request, loads the result register once that register is free.
// After reset all 2**VAR_BITS entries are cleared one per cycle, with req_ready low.
// A result waiting in the output register does not block requests that produce no result;
// only a request that would produce one, and any behind it, waits for the register to drain.
module cnf_clause_evaluator_core #(
   parameter int VAR_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  cnf_eval_pkg::req_payload_type req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output cnf_eval_pkg::rsp_payload_type rsp_data
);
   import cnf_eval_pkg::*;

   localparam int TABLE_DEPTH = 1 << VAR_BITS;

   // Assignment table and its registered read port.
   logic [ENTRY_W-1:0]  assign_mem [TABLE_DEPTH];
   logic [ENTRY_W-1:0]  rd_entry_ff;

   // Clearing pass after reset.
   logic                clearing_ff;
   logic [VAR_BITS-1:0] clr_addr_ff;

   // Evaluation stage.
   logic                s1_valid_ff;
   req_payload_type     s1_req_ff;
   logic [VAR_BITS-1:0] s1_var_ff;

   // Clause and formula state.
   logic                has_true_ff, has_true_in;
   logic                has_open_ff, has_open_in;
   logic                taut_ff, taut_in;
   logic                bad_ff, bad_in;
   logic [VAR_BITS-1:0] prev_var_ff, prev_var_in;
   logic                prev_neg_ff, prev_neg_in;
   logic                prev_present_ff, prev_present_in;
   logic                fv_acc_ff, fv_acc_in;
   logic                fc_acc_ff, fc_acc_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_data_ff, rsp_data_in;

   // Handshake and memory control.
   logic                req_accept;
   logic                s1_closes;
   logic                s1_adv;
   logic [VAR_BITS+VAR_INDEX_W-1:0] req_var_ext;
   logic [VAR_BITS-1:0] req_var;
   logic                mem_we;
   logic [VAR_BITS-1:0] mem_waddr;
   logic [ENTRY_W-1:0]  mem_wdata;

   // Evaluation terms.
   logic                lit_bad;
   logic                lit_taut;
   logic                lit_assigned;
   logic                cur_true, cur_open, cur_taut, cur_bad;
   logic                cv, cc, fv, fc;

   // Only the low VAR_BITS bits of the variable number address the table.
   assign req_var_ext = {{VAR_BITS{1'b0}}, req_data.variable_index};
   assign req_var     = req_var_ext[VAR_BITS-1:0];

   // The stage holding a closing request moves on only when the result register is free.
   assign s1_closes  = (s1_req_ff.opcode == OP_CLOSE) ||
                       ((s1_req_ff.opcode == OP_LITERAL) && s1_req_ff.last_in_clause);
   assign s1_adv     = s1_valid_ff && (!s1_closes || !rsp_valid_ff || rsp_ready);
   assign req_ready  = !clearing_ff && (!s1_valid_ff || s1_adv);
   assign req_accept = req_valid && req_ready;

   // Table writes: clearing pass first, then assign and unassign requests at acceptance.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = req_var;
      mem_wdata = ENTRY_UNASSIGNED;
      if (clearing_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
      end else if (req_accept && req_data.opcode == OP_ASSIGN) begin
         mem_we    = 1'b1;
         mem_wdata = req_data.assign_value ? ENTRY_TRUE : ENTRY_FALSE;
      end else if (req_accept && req_data.opcode == OP_UNASSIGN) begin
         mem_we    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         assign_mem[mem_waddr] <= mem_wdata;
      end
      if (req_accept) begin
         rd_entry_ff <= assign_mem[req_var];
      end
   end

   // Clearing pass sequencing.
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == {VAR_BITS{1'b1}}) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // Input register stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_data;
         s1_var_ff <= req_var;
      end
   end

   // Literal evaluation, clause close and next state.
   always_comb begin
      lit_bad      = (s1_var_ff == '0);
      lit_taut     = prev_present_ff && (prev_var_ff == s1_var_ff) &&
                     (prev_neg_ff != s1_req_ff.literal_negated);
      lit_assigned = (rd_entry_ff == ENTRY_TRUE) || (rd_entry_ff == ENTRY_FALSE);

      cur_true        = has_true_ff;
      cur_open        = has_open_ff;
      cur_taut        = taut_ff;
      cur_bad         = bad_ff;
      prev_var_in     = prev_var_ff;
      prev_neg_in     = prev_neg_ff;
      prev_present_in = prev_present_ff;

      // A literal on variable zero only marks the clause.
      if (s1_req_ff.opcode == OP_LITERAL) begin
         if (lit_bad) begin
            cur_bad = 1'b1;
         end else begin
            cur_taut        = taut_ff || lit_taut;
            cur_true        = has_true_ff || (lit_assigned &&
                              ((rd_entry_ff == ENTRY_TRUE) != s1_req_ff.literal_negated));
            cur_open        = has_open_ff || !lit_assigned;
            prev_var_in     = s1_var_ff;
            prev_neg_in     = s1_req_ff.literal_negated;
            prev_present_in = 1'b1;
         end
      end

      cv = cur_taut || cur_true || cur_open;
      cc = cur_taut || cur_true;
      fv = fv_acc_ff && cv;
      fc = fc_acc_ff && cc;

      has_true_in = has_true_ff;
      has_open_in = has_open_ff;
      taut_in     = taut_ff;
      bad_in      = bad_ff;
      fv_acc_in   = fv_acc_ff;
      fc_acc_in   = fc_acc_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (s1_adv) begin
         has_true_in = cur_true;
         has_open_in = cur_open;
         taut_in     = cur_taut;
         bad_in      = cur_bad;
         if (s1_closes) begin
            rsp_valid_in                 = 1'b1;
            rsp_data_in.clause_valid     = cv;
            rsp_data_in.clause_complete  = cc;
            rsp_data_in.formula_valid    = fv;
            rsp_data_in.formula_complete = fc;
            rsp_data_in.formula_end      = s1_req_ff.last_in_formula;
            rsp_data_in.bad_literal      = cur_bad;
            fv_acc_in       = s1_req_ff.last_in_formula ? 1'b1 : fv;
            fc_acc_in       = s1_req_ff.last_in_formula ? 1'b1 : fc;
            has_true_in     = 1'b0;
            has_open_in     = 1'b0;
            taut_in         = 1'b0;
            bad_in          = 1'b0;
            prev_var_in     = '0;
            prev_neg_in     = 1'b0;
            prev_present_in = 1'b0;
         end
      end else begin
         prev_var_in     = prev_var_ff;
         prev_neg_in     = prev_neg_ff;
         prev_present_in = prev_present_ff;
      end
   end

   // Clause and formula state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         has_true_ff     <= 1'b0;
         has_open_ff     <= 1'b0;
         taut_ff         <= 1'b0;
         bad_ff          <= 1'b0;
         prev_var_ff     <= '0;
         prev_neg_ff     <= 1'b0;
         prev_present_ff <= 1'b0;
         fv_acc_ff       <= 1'b1;
         fc_acc_ff       <= 1'b1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         has_true_ff     <= has_true_in;
         has_open_ff     <= has_open_in;
         taut_ff         <= taut_in;
         bad_ff          <= bad_in;
         prev_var_ff     <= prev_var_in;
         prev_neg_ff     <= prev_neg_in;
         prev_present_ff <= prev_present_in;
         fv_acc_ff       <= fv_acc_in;
         fc_acc_ff       <= fc_acc_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A complete clause is always valid, and so is the formula.
   a_clause_complete_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff.clause_complete || rsp_data_ff.clause_valid))
      else $error("clause reported complete but not valid");

   a_formula_complete_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff.formula_complete || rsp_data_ff.formula_valid))
      else $error("formula reported complete but not valid");

   // Closing a formula restarts both accumulators.
   a_formula_restart: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_closes && s1_req_ff.last_in_formula) |=> (fv_acc_ff && fc_acc_ff))
      else $error("formula accumulators not restarted after formula end");

   // No request reaches evaluation while the table is being cleared.
   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !s1_valid_ff)
      else $error("request in flight during table clearing");

   // The clearing pass ends only after the last table entry.
   a_clear_span: assert property (@(posedge clock) disable iff (reset)
      $fell(clearing_ff) |-> ($past(clr_addr_ff) == {VAR_BITS{1'b1}}))
      else $error("table clearing ended early");

endmodule
